FILE: hw/rtl/rgbc_pkg.sv
// Shared types, constants and codes for the RGB 3x3 convolution filter.
// No dependencies; the top level, rgbc_col_cell and rgbc_kernel use rgbc_pkg by scoped names.
`default_nettype none

package rgbc_pkg;

    // Line buffer geometry
    localparam int LINE_DEPTH = 1024;
    localparam int COL_W      = $clog2(LINE_DEPTH);

    // Configuration field widths
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int ROW_W      = HEIGHT_W;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Smallest frame side that has an interior, and the widest frame the line buffers hold
    localparam logic [WIDTH_W-1:0]  MIN_WIDTH  = WIDTH_W'(3);
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT = HEIGHT_W'(3);
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH  = WIDTH_W'(LINE_DEPTH);

    // Register reset values
    localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(480);

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_KERNEL_SELECT = 2'd2
    } reg_index_t;

    // Kernel codes
    typedef enum logic [1:0] {
        KERNEL_DX      = 2'd0,
        KERNEL_DY      = 2'd1,
        KERNEL_BLUR    = 2'd2,
        KERNEL_SHARPEN = 2'd3
    } kernel_t;

    // One pixel, packed as blue in the low byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // One window column, top to bottom
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rgb_3x3_convolution_filter.sv
// Top level of the RGB 3x3 convolution filter: APB registers, position
// counters, line buffers, window cell chain and output register.
// Depends on rgbc_pkg, rgbc_ram, rgbc_col_cell and rgbc_kernel.
//
//   Channel  | Handshake                    | Payload
//   ---------+------------------------------+-----------------------------------------
//   pixel    | pixel_valid / pixel_stall    | pixel_blue/green/red, frame_start
//   result   | result_valid / result_stall  | filtered_blue/green/red, frame_done
//   config   | psel/penable/pwrite/pready   | paddr, pwdata, prdata
//
// One pixel per clock sustained unless a stalled result blocks; results are registered.
// The figure is set by the line buffer RAMs: one read and one write per cycle,
// with a forward when a pixel revisits the column just written.
// Reset clears counters, configuration registers and handshake state; the line buffers are
// not cleared and need two full rows of a frame before a result uses them.
// A stalled result holds its output register; the pixel side stalls only
// when an interior pixel waits behind it.
`default_nettype none

module rgb_3x3_convolution_filter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Pixel channel
    input  wire logic                          pixel_valid,
    output      logic                          pixel_stall,
    input  wire logic [7:0]                    pixel_blue,
    input  wire logic [7:0]                    pixel_green,
    input  wire logic [7:0]                    pixel_red,
    input  wire logic                          frame_start,
    // Result channel
    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output      logic [7:0]                    filtered_blue,
    output      logic [7:0]                    filtered_green,
    output      logic [7:0]                    filtered_red,
    output      logic                          frame_done,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rgbc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rgbc_pkg::PDATA_W-1:0]  pwdata,
    output      logic [rgbc_pkg::PDATA_W-1:0]  prdata,
    output      logic                          pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rgbc_pkg::WIDTH_W-1:0]  frame_width_reg;
    logic [rgbc_pkg::HEIGHT_W-1:0] frame_height_reg;
    rgbc_pkg::kernel_t             kernel_sel_reg;
    rgbc_pkg::reg_index_t          reg_index;
    logic                          cfg_write;

    assign pready    = 1'b1;
    assign reg_index = rgbc_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rgbc_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= rgbc_pkg::FRAME_HEIGHT_RST;
            kernel_sel_reg   <= rgbc_pkg::KERNEL_BLUR;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                rgbc_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= pwdata[rgbc_pkg::WIDTH_W-1:0];
                end
                rgbc_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= pwdata[rgbc_pkg::HEIGHT_W-1:0];
                end
                rgbc_pkg::REG_KERNEL_SELECT:
                begin
                    kernel_sel_reg <= rgbc_pkg::kernel_t'(pwdata[1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_index)
            rgbc_pkg::REG_FRAME_WIDTH:
            begin
                prdata = rgbc_pkg::PDATA_W'(frame_width_reg);
            end
            rgbc_pkg::REG_FRAME_HEIGHT:
            begin
                prdata = rgbc_pkg::PDATA_W'(frame_height_reg);
            end
            rgbc_pkg::REG_KERNEL_SELECT:
            begin
                prdata = rgbc_pkg::PDATA_W'(kernel_sel_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Effective frame size
    // ------------------------------------------------------------------
    logic [rgbc_pkg::WIDTH_W-1:0]  eff_width;
    logic [rgbc_pkg::HEIGHT_W-1:0] eff_height;

    always_comb
    begin
        if (frame_width_reg < rgbc_pkg::MIN_WIDTH)
        begin
            eff_width = rgbc_pkg::MIN_WIDTH;
        end
        else if (frame_width_reg > rgbc_pkg::MAX_WIDTH)
        begin
            eff_width = rgbc_pkg::MAX_WIDTH;
        end
        else
        begin
            eff_width = frame_width_reg;
        end
        eff_height = (frame_height_reg < rgbc_pkg::MIN_HEIGHT) ? rgbc_pkg::MIN_HEIGHT
                                                               : frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_emit_reg;
    logic s1_done_reg;
    logic s1_go;
    logic pixel_accept;
    logic result_valid_reg;

    // Stage 1 leaves when it has no result or the output register frees up
    assign s1_go        = s1_valid_reg && (!s1_emit_reg || !result_valid_reg || !result_stall);
    assign pixel_stall  = s1_valid_reg && !s1_go;
    assign pixel_accept = pixel_valid && !pixel_stall;

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [rgbc_pkg::COL_W-1:0] col_reg, col_next;
    logic [rgbc_pkg::ROW_W-1:0] row_reg, row_next;
    logic [rgbc_pkg::COL_W-1:0] col_start, col_cur;
    logic [rgbc_pkg::ROW_W-1:0] row_start, row_cur;
    logic                       col_last, row_last;
    logic                       cur_emit, cur_done;

    always_comb
    begin
        // Restart on frame start, wrap a counter beyond the frame
        col_start = frame_start ? '0 : col_reg;
        row_start = frame_start ? '0 : row_reg;
        col_cur   = ({1'b0, col_start} >= eff_width) ? '0 : col_start;
        row_cur   = (row_start >= eff_height) ? '0 : row_start;
        col_last  = ({1'b0, col_cur} == (eff_width - rgbc_pkg::WIDTH_W'(1)));
        row_last  = (row_cur == (eff_height - rgbc_pkg::HEIGHT_W'(1)));
        cur_emit  = (col_cur >= rgbc_pkg::COL_W'(2)) && (row_cur >= rgbc_pkg::ROW_W'(2));
        cur_done  = col_last && row_last;
        // Advance to the next pixel position
        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_cur + rgbc_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + rgbc_pkg::COL_W'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pixel_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line buffer data arrives, window and kernels work
    // ------------------------------------------------------------------
    logic [rgbc_pkg::COL_W-1:0] s1_col_reg;
    rgbc_pkg::pixel_t           s1_pix_reg;
    logic                       s1_byp_reg;
    rgbc_pkg::pixel_t           s1_byp_top_reg;
    rgbc_pkg::pixel_t           s1_byp_mid_reg;
    rgbc_pkg::pixel_t           upper_rdata, middle_rdata;
    rgbc_pkg::pixel_t           s1_top, s1_mid;
    logic                       byp_hit;

    // Forward the column being written when the next pixel reads it
    assign byp_hit = s1_go && (s1_col_reg == col_cur);
    assign s1_top  = s1_byp_reg ? s1_byp_top_reg : upper_rdata;
    assign s1_mid  = s1_byp_reg ? s1_byp_mid_reg : middle_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Capture the request's payload and position flags
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_col_reg       <= col_cur;
            s1_emit_reg      <= cur_emit;
            s1_done_reg      <= cur_done;
            s1_pix_reg.blue  <= pixel_blue;
            s1_pix_reg.green <= pixel_green;
            s1_pix_reg.red   <= pixel_red;
            s1_byp_reg       <= byp_hit;
            s1_byp_top_reg   <= s1_mid;
            s1_byp_mid_reg   <= s1_pix_reg;
        end
    end

    // Line buffers: row r-2 and row r-1
    rgbc_ram #(
        .WIDTH ($bits(rgbc_pkg::pixel_t)),
        .DEPTH (rgbc_pkg::LINE_DEPTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (s1_mid),
        .re    (pixel_accept),
        .raddr (col_cur),
        .rdata (upper_rdata)
    );

    rgbc_ram #(
        .WIDTH ($bits(rgbc_pkg::pixel_t)),
        .DEPTH (rgbc_pkg::LINE_DEPTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (pixel_accept),
        .raddr (col_cur),
        .rdata (middle_rdata)
    );

    // Window: newest column feeds cell 1, cell 1 feeds cell 0
    rgbc_pkg::column_t new_col, mid_col, old_col;

    assign new_col.top = s1_top;
    assign new_col.mid = s1_mid;
    assign new_col.bot = s1_pix_reg;

    rgbc_col_cell u_cell1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s1_go),
        .col_in  (new_col),
        .col_out (mid_col)
    );

    rgbc_col_cell u_cell0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s1_go),
        .col_in  (mid_col),
        .col_out (old_col)
    );

    // Gather the 3x3 taps of each channel
    logic [2:0][2:0][7:0] taps_blue, taps_green, taps_red;
    logic [7:0]           k_blue, k_green, k_red;

    always_comb
    begin
        taps_blue[0]  = {new_col.top.blue,  mid_col.top.blue,  old_col.top.blue};
        taps_blue[1]  = {new_col.mid.blue,  mid_col.mid.blue,  old_col.mid.blue};
        taps_blue[2]  = {new_col.bot.blue,  mid_col.bot.blue,  old_col.bot.blue};
        taps_green[0] = {new_col.top.green, mid_col.top.green, old_col.top.green};
        taps_green[1] = {new_col.mid.green, mid_col.mid.green, old_col.mid.green};
        taps_green[2] = {new_col.bot.green, mid_col.bot.green, old_col.bot.green};
        taps_red[0]   = {new_col.top.red,   mid_col.top.red,   old_col.top.red};
        taps_red[1]   = {new_col.mid.red,   mid_col.mid.red,   old_col.mid.red};
        taps_red[2]   = {new_col.bot.red,   mid_col.bot.red,   old_col.bot.red};
    end

    rgbc_kernel u_kernel_blue (
        .kernel_sel (kernel_sel_reg),
        .taps       (taps_blue),
        .result     (k_blue)
    );

    rgbc_kernel u_kernel_green (
        .kernel_sel (kernel_sel_reg),
        .taps       (taps_green),
        .result     (k_green)
    );

    rgbc_kernel u_kernel_red (
        .kernel_sel (kernel_sel_reg),
        .taps       (taps_red),
        .result     (k_red)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic       out_load;
    logic [7:0] out_blue_reg, out_green_reg, out_red_reg;
    logic       out_done_reg;

    assign out_load = s1_go && s1_emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_blue_reg  <= k_blue;
            out_green_reg <= k_green;
            out_red_reg   <= k_red;
            out_done_reg  <= s1_done_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign filtered_blue  = out_blue_reg;
    assign filtered_green = out_green_reg;
    assign filtered_red   = out_red_reg;
    assign frame_done     = out_done_reg;

`ifndef SYNTHESIS
    // A forwarded column can only be a repeat of column zero
    a_byp_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_byp_reg) |-> (s1_col_reg == '0))
        else $error("line buffer forward on a nonzero column");

    // An interior pixel leaving stage 1 shows up at the output
    a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result_valid)
        else $error("interior pixel lost between stage 1 and output");

    // Pixel side stalls only behind a waiting stage 1 request
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (s1_valid_reg && s1_emit_reg && result_valid_reg))
        else $error("pixel stall without a blocked interior request");

    // A held stage 1 request keeps its column
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stage 1 request changed while held");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/rgbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rgbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbc_col_cell.sv
// One window column cell: holds three pixels and passes them to its neighbor.
// Depends on rgbc_pkg for column_t.
`default_nettype none

module rgbc_col_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift,
    input  wire rgbc_pkg::column_t col_in,
    output      rgbc_pkg::column_t col_out
);

    rgbc_pkg::column_t col_reg;

    // Advance the column by one place on each shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rgbc_kernel.sv
// 3x3 kernel on one color channel with clamp to 0..255.
// Depends on rgbc_pkg for kernel_t.
`default_nettype none

module rgbc_kernel (
    input  wire rgbc_pkg::kernel_t         kernel_sel,
    input  wire logic [2:0][2:0][7:0]      taps,      // [row][col], row 0 top
    output      logic [7:0]                result
);

    logic signed [12:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;
    logic signed [12:0] sum;

    // Widen taps to signed
    assign p00 = signed'({5'b0, taps[0][0]});
    assign p01 = signed'({5'b0, taps[0][1]});
    assign p02 = signed'({5'b0, taps[0][2]});
    assign p10 = signed'({5'b0, taps[1][0]});
    assign p11 = signed'({5'b0, taps[1][1]});
    assign p12 = signed'({5'b0, taps[1][2]});
    assign p20 = signed'({5'b0, taps[2][0]});
    assign p21 = signed'({5'b0, taps[2][1]});
    assign p22 = signed'({5'b0, taps[2][2]});

    // Weighted sum for the selected kernel
    always_comb
    begin
        case (kernel_sel)
            rgbc_pkg::KERNEL_DX:
            begin
                sum = (p02 + p12 + p22) - (p00 + p10 + p20);
            end
            rgbc_pkg::KERNEL_DY:
            begin
                sum = (p20 + p21 + p22) - (p00 + p01 + p02);
            end
            rgbc_pkg::KERNEL_BLUR:
            begin
                // Sum never negative, so the shift is a floor divide by 16
                sum = (p00 + (p01 <<< 1) + p02
                     + (p10 <<< 1) + (p11 <<< 2) + (p12 <<< 1)
                     + p20 + (p21 <<< 1) + p22) >>> 4;
            end
            rgbc_pkg::KERNEL_SHARPEN:
            begin
                sum = ((p11 <<< 3) + p11)
                    - (p00 + p01 + p02 + p10 + p12 + p20 + p21 + p22);
            end
            default:
            begin
                sum = '0;
            end
        endcase
    end

    // Clamp to a byte
    always_comb
    begin
        if (sum < 0)
        begin
            result = 8'd0;
        end
        else if (sum > 13'sd255)
        begin
            result = 8'd255;
        end
        else
        begin
            result = sum[7:0];
        end
    end

endmodule

`default_nettype wire
